// ===== hw/rtl/stpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared types and constants for the two-key sorted priority queue.
// ----------------------------------------------------------------------------
package stpq_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data;
      logic [KEY_W-1:0]      prio;
      logic [KEY_W-1:0]      subpriority;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stpq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_cell
// One slot of the sorted row: compares the incoming key with its own entry,
// then holds, loads the new word, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module stpq_cell
   import stpq_pkg::*;
(
   input  wire logic           clock,
   input  wire shift_ctrl_type ctrl,
   input  wire entry_type      new_entry,
   input  wire logic           occupied,
   input  wire logic           left_goes_first,
   input  wire entry_type      left_entry,
   input  wire entry_type      right_entry,
   output      logic           goes_first,
   output      entry_type      entry_q,
   output      entry_type      entry_next
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      goes_first = !occupied
            || (new_entry.prio < entry_ff.prio)
            || ((new_entry.prio == entry_ff.prio)
                && (new_entry.subpriority < entry_ff.subpriority));
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (left_goes_first) begin
            entry_in = left_entry;
         end else if (goes_first) begin
            entry_in = new_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q    = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

// ===== hw/rtl/stable_two_key_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stable_two_key_priority_queue
// Min-priority queue kept sorted in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Takes one push, pop or clear word per clock cycle while the result side
// is not stalled, and returns the registered result word in the next cycle.
// All cells compare the pushed key against their own entry in parallel and
// shift in the same cycle; the per-cell key compare feeding the shift select
// sets the cycle time. Entries order by priority, then subpriority, lowest
// first, and equal keys leave in arrival order. A push when full is dropped
// (status 1), a pop when empty is refused (status 2). The head fields read
// zero when the queue is empty. The result register lets a new request in
// while the previous result waits, as long as the result side is not stalled.
// ----------------------------------------------------------------------------
module stable_two_key_priority_queue
   import stpq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [31:0]         req_item_data,
   input  wire logic [KEY_W-1:0]    req_item_priority,
   input  wire logic [KEY_W-1:0]    req_item_subpriority,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [31:0]         rsp_head_data,
   output      logic [KEY_W-1:0]    rsp_head_priority,
   output      logic [KEY_W-1:0]    rsp_head_subpriority,
   output      logic                rsp_is_empty,
   output      logic                rsp_is_full,
   output      logic [STATUS_W-1:0] rsp_status
);

   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [31:0]         head_data_ff;
   logic [KEY_W-1:0]    head_prio_ff;
   logic [KEY_W-1:0]    head_sub_ff;
   logic                empty_ff;
   logic                full_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   logic           accept;
   logic           is_empty_now;
   logic           is_full_now;
   shift_ctrl_type ctrl;
   entry_type      new_entry;
   entry_type      cell_q     [CAPACITY];
   entry_type      cell_next  [CAPACITY];
   logic           goes_first [CAPACITY];

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == COUNT_W'(CAPACITY));

   always_comb begin
      new_entry.data        = DATA_WIDTH'(req_item_data);
      new_entry.prio        = req_item_priority;
      new_entry.subpriority = req_item_subpriority;
   end

   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = ST_OK;
      if (accept) begin
         unique case (req_operation)
            OP_PUSH: begin
               if (is_full_now) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.push = 1'b1;
                  count_in  = count_ff + COUNT_W'(1);
               end
            end
            OP_POP: begin
               if (is_empty_now) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctrl.pop = 1'b1;
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            OP_NONE: begin
               count_in = count_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      left_goes_first;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_goes_first = 1'b0;
         assign left_entry      = cell_q[0];
      end else begin : g_body
         assign left_goes_first = goes_first[i-1];
         assign left_entry      = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_q[i];
      end else begin : g_mid
         assign right_entry = cell_q[i+1];
      end

      stpq_cell u_cell (
         .clock           (clock),
         .ctrl            (ctrl),
         .new_entry       (new_entry),
         .occupied        (occupied),
         .left_goes_first (left_goes_first),
         .left_entry      (left_entry),
         .right_entry     (right_entry),
         .goes_first      (goes_first[i]),
         .entry_q         (cell_q[i]),
         .entry_next      (cell_next[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_in == '0) begin
            head_data_ff <= '0;
            head_prio_ff <= '0;
            head_sub_ff  <= '0;
         end else begin
            head_data_ff <= 32'(cell_next[0].data);
            head_prio_ff <= cell_next[0].prio;
            head_sub_ff  <= cell_next[0].subpriority;
         end
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in == COUNT_W'(CAPACITY));
         status_ff <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_head_data        = head_data_ff;
   assign rsp_head_priority    = head_prio_ff;
   assign rsp_head_subpriority = head_sub_ff;
   assign rsp_is_empty         = empty_ff;
   assign rsp_is_full          = full_ff;
   assign rsp_status           = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(empty_ff && full_ff))
      else $error("result both empty and full");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> full_ff)
      else $error("dropped push while not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_EMPTY) |-> (empty_ff && head_prio_ff == '0))
      else $error("refused pop while not empty");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("push did not add an entry");

endmodule

`default_nettype wire
